// ===== rtl/bmw_pkg.sv =====
// bmw_pkg.sv: types and constants shared by the binary morphology window modules
// depends on nothing; imported by every module of the block
package bmw_pkg;

	localparam int CHAN_W = 8;
	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

	localparam int RADIUS_W     = 2;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	localparam logic [RADIUS_W-1:0]     RADIUS_RST = 2'd1;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd1024;

	// row counters run a few rows past the largest height while the frame drains
	localparam int ROW_W = 14;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic res;
		logic mode;
		logic last;
	} item_ctl_t;

	typedef struct packed {
		logic white;
		logic last;
	} result_t;

endpackage

// ===== rtl/bmw_ctrl.sv =====
// bmw_ctrl.sv: configuration registers, frame position counters and first pipeline stage
// depends on bmw_pkg; feeds bmw_linebuf and bmw_window
module bmw_ctrl
	import bmw_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int VEC_W = 2 * MAX_RADIUS + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_fire,
	input  logic [CHAN_W-1:0]       blue,
	input  logic [CHAN_W-1:0]       green,
	input  logic [CHAN_W-1:0]       red,
	input  logic                    flush,
	output logic                    rd_en,
	output logic [COL_W-1:0]        rd_addr,
	output logic                    s1_valid,
	output item_ctl_t               s1_ctl,
	output logic                    s1_bit,
	output logic [COL_W-1:0]        s1_addr,
	output logic [VEC_W-1:0]        s1_row_ok,
	output logic [VEC_W-1:0]        s1_col_ok
);

	localparam int CCW   = (COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W;
	localparam int CW1   = CCW + 1;
	localparam int RW1   = ROW_W + 1;
	localparam int LAG_W = RADIUS_W + WIDTH_REG_W + 1;
	localparam int KW    = $clog2(VEC_W) + 1;
	localparam int CMP_W = 14;

	logic                    mode_q;
	logic [RADIUS_W-1:0]     radius_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	logic                    fmode_q;
	logic [RADIUS_W-1:0]     fr_q;
	logic [WIDTH_REG_W-1:0]  fw_q;
	logic [HEIGHT_REG_W-1:0] fh_q;

	logic                    active_q;
	logic                    done_q;
	logic [CCW-1:0]          vcol_q;
	logic [ROW_W-1:0]        vrow_q;
	logic [CCW-1:0]          ocol_q;
	logic [ROW_W-1:0]        orow_q;
	logic [LAG_W-1:0]        lead_q;

	logic [WIDTH_REG_W-1:0]  w_cfg;
	logic [WIDTH_REG_W-1:0]  w_cur;
	logic [HEIGHT_REG_W-1:0] h_cfg;
	logic [HEIGHT_REG_W-1:0] h_cur;
	logic [RADIUS_W-1:0]     r_cfg;
	logic [RADIUS_W-1:0]     r_cur;
	logic                    m_cur;
	logic                    start;
	logic                    is_pixel;
	logic                    take;
	logic                    pix_bit;
	logic                    res;
	logic                    last;
	logic                    col_wrap;
	logic                    ocol_wrap;
	logic                    in_last;
	logic [LAG_W-1:0]        lag;
	logic [CCW-1:0]          w_m1;
	logic [ROW_W-1:0]        h_m1;
	logic [CW1-1:0]          ocol_r;
	logic [RW1-1:0]          orow_r;
	logic [VEC_W-1:0]        row_ok;
	logic [VEC_W-1:0]        col_ok;

	// register values as a frame uses them
	always_comb begin
		w_cfg = width_q;
		if (width_q == '0)
			w_cfg = WIDTH_REG_W'(1);
		else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH))
			w_cfg = WIDTH_REG_W'(MAX_WIDTH);
		h_cfg = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
		r_cfg = (4'(radius_q) > 4'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
	end

	assign start = !active_q;
	assign w_cur = start ? w_cfg : fw_q;
	assign h_cur = start ? h_cfg : fh_q;
	assign r_cur = start ? r_cfg : fr_q;
	assign m_cur = start ? mode_q : fmode_q;

	assign lag      = LAG_W'(r_cur) * LAG_W'(w_cur) + LAG_W'(r_cur);
	assign is_pixel = !done_q && !flush;
	// early padding is dropped at the input
	assign take     = in_fire && !(!done_q && flush);
	assign pix_bit  = is_pixel && ((m_cur == MODE_DILATE) ?
		(blue == CHAN_FULL && green == CHAN_FULL && red == CHAN_FULL) :
		(blue == CHAN_ZERO && green == CHAN_ZERO && red == CHAN_ZERO));
	assign res       = (lead_q >= lag);
	assign w_m1      = CCW'(w_cur) - CCW'(1);
	assign h_m1      = ROW_W'(h_cur) - ROW_W'(1);
	assign col_wrap  = (vcol_q == w_m1);
	assign in_last   = col_wrap && (vrow_q == h_m1);
	assign ocol_wrap = (ocol_q == w_m1);
	assign last      = res && ocol_wrap && (orow_q == h_m1);
	assign ocol_r    = CW1'(ocol_q) + CW1'(r_cur);
	assign orow_r    = RW1'(orow_q) + RW1'(r_cur);

	// window bounds: element k is offset r - k from the result pixel
	always_comb begin
		for (int k = 0; k < VEC_W; k++) begin
			row_ok[k] = (orow_r >= RW1'(k)) && ((orow_r - RW1'(k)) < RW1'(h_cur)) &&
				(KW'(k) <= (KW'(r_cur) << 1));
			col_ok[k] = (ocol_r >= CW1'(k)) && ((ocol_r - CW1'(k)) < CW1'(w_cur)) &&
				(KW'(k) <= (KW'(r_cur) << 1));
		end
	end

	assign rd_en   = take;
	assign rd_addr = vcol_q[COL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DILATE;
			radius_q <= RADIUS_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmode_q  <= MODE_DILATE;
			fr_q     <= RADIUS_W'(1);
			fw_q     <= WIDTH_REG_W'(1);
			fh_q     <= HEIGHT_REG_W'(1);
			active_q <= 1'b0;
			done_q   <= 1'b0;
			vcol_q   <= '0;
			vrow_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			lead_q   <= '0;
		end else if (take) begin
			if (start) begin
				fmode_q <= m_cur;
				fr_q    <= r_cur;
				fw_q    <= w_cur;
				fh_q    <= h_cur;
			end
			if (last) begin
				active_q <= 1'b0;
				done_q   <= 1'b0;
				vcol_q   <= '0;
				vrow_q   <= '0;
				ocol_q   <= '0;
				orow_q   <= '0;
				lead_q   <= '0;
			end else begin
				active_q <= 1'b1;
				if (is_pixel && in_last)
					done_q <= 1'b1;
				if (col_wrap) begin
					vcol_q <= '0;
					vrow_q <= vrow_q + ROW_W'(1);
				end else begin
					vcol_q <= vcol_q + CCW'(1);
				end
				if (res) begin
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + ROW_W'(1);
					end else begin
						ocol_q <= ocol_q + CCW'(1);
					end
				end else begin
					lead_q <= lead_q + LAG_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else
			s1_valid <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_ctl.res  <= res;
			s1_ctl.mode <= m_cur;
			s1_ctl.last <= last;
			s1_bit      <= pix_bit;
			s1_addr     <= rd_addr;
			s1_row_ok   <= row_ok;
			s1_col_ok   <= col_ok;
		end
	end

endmodule

// ===== rtl/bmw_linebuf.sv =====
// bmw_linebuf.sv: line buffer memory, one word per column holding the previous rows
// depends on bmw_pkg; registered read with bypass of the write in the same cycle
module bmw_linebuf
	import bmw_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 6,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic              fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// one-pixel rows read the word being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_q <= 1'b0;
		else if (rd_en)
			fwd_q <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/bmw_window.sv =====
// bmw_window.sv: square window shift register, bounds mask and hit reduction
// depends on bmw_pkg; takes column vectors from the first stage
module bmw_window
	import bmw_pkg::*;
#(
	parameter int MAX_RADIUS = 3,
	localparam int VEC_W = 2 * MAX_RADIUS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  item_ctl_t        s1_ctl,
	input  logic [VEC_W-1:0] s1_vec,
	input  logic [VEC_W-1:0] s1_row_ok,
	input  logic [VEC_W-1:0] s1_col_ok,
	output logic             push,
	output result_t          push_data
);

	logic [VEC_W-1:0] win_q   [VEC_W];
	logic [VEC_W-1:0] mask_s2 [VEC_W];
	logic             s2_valid;
	item_ctl_t        s2_ctl;
	logic             hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid <= 1'b0;
		else
			s2_valid <= s1_valid;
	end

	// column 0 is the newest
	always_ff @(posedge clk) begin
		if (s1_valid) begin
			win_q[0] <= s1_vec;
			for (int a = 1; a < VEC_W; a++)
				win_q[a] <= win_q[a-1];
			for (int a = 0; a < VEC_W; a++)
				mask_s2[a] <= s1_col_ok[a] ? s1_row_ok : '0;
			s2_ctl <= s1_ctl;
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int a = 0; a < VEC_W; a++)
			hit = hit | (|(win_q[a] & mask_s2[a]));
	end

	assign push            = s2_valid && s2_ctl.res;
	assign push_data.white = (s2_ctl.mode == MODE_DILATE) ? hit : !hit;
	assign push_data.last  = s2_ctl.last;

endmodule

// ===== rtl/bmw_outq.sv =====
// bmw_outq.sv: small result queue that decouples the pipeline from the output stall
// depends on bmw_pkg
module bmw_outq
	import bmw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  result_t             push_data,
	input  logic                pop,
	output logic                out_valid,
	output result_t             out_data,
	output logic [OQ_CNT_W-1:0] count
);

	result_t             ent_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop_i;

	assign out_valid = (cnt_q != '0);
	assign pop_i     = pop && out_valid;
	assign out_data  = ent_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			if (pop_i)
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			if (push && !pop_i)
				cnt_q <= cnt_q + OQ_CNT_W'(1);
			else if (pop_i && !push)
				cnt_q <= cnt_q - OQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/binary_morphology_window.sv =====
// binary_morphology_window.sv: top level of the binary square-window dilate / erode block
// depends on bmw_pkg, bmw_ctrl, bmw_linebuf, bmw_window, bmw_outq
//
// usage:
// pixels enter in raster order on the s_axis channel, one transfer per pixel;
// tuser high marks a padding transfer sent after the last pixel to drain the frame
// results leave on m_axis, one bit per pixel, tlast on the last pixel of the frame
// the first result needs r rows plus r pixels of input; padding supplies the tail
// registers are written through cfg_we / cfg_index / cfg_data between frames and
// are sampled by the first transfer of each frame
// throughput: one transfer per clock while s_axis_tready is high; the line buffer port takes one read and one
// write per cycle and the window reduction sits in a single stage
// path: a result passes the first-stage registers, the window registers and the result
// queue before it can leave on m_axis
// reset: registers return to dilate, radius 1, 1024 x 1024 and the frame restarts;
// the line buffer is not cleared, its stale rows fall outside every window
// stall: up to four results queue internally while m_axis_tready is low;
// s_axis_tready drops once queued plus in-flight results reach four
module binary_morphology_window
	import bmw_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // blue, green, red
	input  logic                  s_axis_tuser,  // flush
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_white, zero fill
	output logic                  m_axis_tlast   // frame_end
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int VEC_W = 2 * MAX_RADIUS + 1;
	localparam int LB_W  = 2 * MAX_RADIUS;

	logic                in_fire;
	logic                rd_en;
	logic [COL_W-1:0]    rd_addr;
	logic                s1_valid;
	item_ctl_t           s1_ctl;
	logic                s1_bit;
	logic [COL_W-1:0]    s1_addr;
	logic [VEC_W-1:0]    s1_row_ok;
	logic [VEC_W-1:0]    s1_col_ok;
	logic [LB_W-1:0]     lb_rd_data;
	logic [VEC_W-1:0]    s1_vec;
	logic                push;
	result_t             push_data;
	result_t             out_data;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W-1:0] pend;
	logic                s1_res;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s1_res  = s1_valid && s1_ctl.res;
	assign pend    = oq_count + OQ_CNT_W'(s1_res) + OQ_CNT_W'(push);
	assign s_axis_tready = (pend < OQ_CNT_W'(OQ_DEPTH));

	bmw_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.blue      (s_axis_tdata[7:0]),
		.green     (s_axis_tdata[15:8]),
		.red       (s_axis_tdata[23:16]),
		.flush     (s_axis_tuser),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.s1_valid  (s1_valid),
		.s1_ctl    (s1_ctl),
		.s1_bit    (s1_bit),
		.s1_addr   (s1_addr),
		.s1_row_ok (s1_row_ok),
		.s1_col_ok (s1_col_ok)
	);

	// bit k of the column vector is k rows above the newest pixel
	assign s1_vec = {lb_rd_data, s1_bit};

	bmw_linebuf #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (LB_W)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (s1_valid),
		.wr_addr (s1_addr),
		.wr_data (s1_vec[LB_W-1:0]),
		.rd_data (lb_rd_data)
	);

	bmw_window #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_ctl    (s1_ctl),
		.s1_vec    (s1_vec),
		.s1_row_ok (s1_row_ok),
		.s1_col_ok (s1_col_ok),
		.push      (push),
		.push_data (push_data)
	);

	bmw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (out_data),
		.count     (oq_count)
	);

	assign m_axis_tdata = OUT_DATA_W'(out_data.white);
	assign m_axis_tlast = out_data.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue overcommitted");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid || s1_res || push))
		else $error("input stalled with nothing pending");

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_res |=> push)
		else $error("result lost between stages");

endmodule
